// ===== src/svm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the section visibility mask unit.
// No dependencies.
package svm_pkg;

   localparam int SECTIONS_DEF       = 16;
   localparam int CHUNK_WIDTH_DEF    = 16;
   localparam int CHUNK_DEPTH_DEF    = 16;
   localparam int SECTION_HEIGHT_DEF = 16;

   localparam int MASK_W     = 16;
   localparam int CNT_W      = 5;
   localparam int POS_W      = 24;
   localparam int NRM_W      = 15;
   localparam int CHK_W      = 12;
   localparam int CSEC_W     = 11;
   localparam int DOWN_W     = 5;
   localparam int PIDX_W     = 3;
   localparam int SY_W       = 4;
   localparam int MINSEC_W   = 12;
   localparam int PLANE_COUNT = 6;
   localparam int AXES       = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int MUL_W      = 30;
   localparam int ACC_W      = 62;

   localparam logic signed [ACC_W-1:0] DIST_LIMIT = ACC_W'(64'd5898240000);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CAMERA_SEC   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DOWN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRUSTUM_EN   = 3'd5;

   typedef struct packed {
      logic init;
      logic mul;
      logic acc;
   } mac_ctl_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic signed [POS_W-1:0]  z;
      logic signed [CSEC_W-1:0] section;
      logic [DOWN_W-1:0]        max_down;
      logic                     frustum_en;
   } cam_type;

   typedef struct packed {
      logic [MASK_W-1:0] visible_mask;
      logic [CNT_W-1:0]  tested_count;
      logic [CNT_W-1:0]  below_culled;
      logic [CNT_W-1:0]  frustum_culled;
      logic [CNT_W-1:0]  distance_culled;
   } res_type;

endpackage

// ===== src/svm_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: plane loads and chunk queries.
// Depends on svm_pkg.
interface svm_req_if;
   import svm_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [PIDX_W-1:0]        plane_index;
   logic signed [NRM_W-1:0]  normal_x;
   logic signed [NRM_W-1:0]  normal_y;
   logic signed [NRM_W-1:0]  normal_z;
   logic signed [POS_W-1:0]  plane_offset;
   logic signed [CHK_W-1:0]  chunk_x;
   logic signed [CHK_W-1:0]  chunk_z;
   logic [MASK_W-1:0]        nonempty_mask;

   modport source (output valid, operation, plane_index, normal_x, normal_y, normal_z,
                   plane_offset, chunk_x, chunk_z, nonempty_mask, input ready);
   modport sink   (input valid, operation, plane_index, normal_x, normal_y, normal_z,
                   plane_offset, chunk_x, chunk_z, nonempty_mask, output ready);
endinterface

// ===== src/svm_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel: visible mask and cull counts of one query.
// Depends on svm_pkg.
interface svm_rsp_if;
   import svm_pkg::*;
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] visible_mask;
   logic [CNT_W-1:0]  tested_count;
   logic [CNT_W-1:0]  below_culled;
   logic [CNT_W-1:0]  frustum_culled;
   logic [CNT_W-1:0]  distance_culled;

   modport source (output valid, visible_mask, tested_count, below_culled,
                   frustum_culled, distance_culled, input ready);
   modport sink   (input valid, visible_mask, tested_count, below_culled,
                   frustum_culled, distance_culled, output ready);
endinterface

// ===== src/svm_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered product, accumulator.
// Depends on svm_pkg.
module svm_mac (
   input  logic                             clock,
   input  svm_pkg::mac_ctl_type             ctl,
   input  logic signed [svm_pkg::MUL_W-1:0] a,
   input  logic signed [svm_pkg::MUL_W-1:0] b,
   input  logic signed [svm_pkg::ACC_W-1:0] init_value,
   output logic signed [svm_pkg::ACC_W-1:0] acc_sum
);
   import svm_pkg::*;

   logic signed [2*MUL_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   always_comb begin
      prod_in = ctl.mul ? a * b : prod_ff;
      acc_sum = acc_ff + ACC_W'(prod_ff);
      if (ctl.init) begin
         acc_in = init_value;
      end else if (ctl.acc) begin
         acc_in = acc_sum;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end
endmodule

// ===== src/svm_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: plane store, per-section walk, plane and distance terms on svm_mac.
// Depends on svm_pkg, svm_req_if, svm_mac.
module svm_seq #(
   parameter int SECTIONS       = svm_pkg::SECTIONS_DEF,
   parameter int CHUNK_WIDTH    = svm_pkg::CHUNK_WIDTH_DEF,
   parameter int CHUNK_DEPTH    = svm_pkg::CHUNK_DEPTH_DEF,
   parameter int SECTION_HEIGHT = svm_pkg::SECTION_HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   svm_req_if.sink          req,
   input  svm_pkg::cam_type cam,
   output svm_pkg::res_type result,
   output logic             result_valid,
   input  logic             result_take
);
   import svm_pkg::*;

   localparam int NSEC = (SECTIONS < MASK_W) ? SECTIONS : MASK_W;
   localparam logic [SY_W-1:0] LAST_SY = SY_W'(NSEC - 1);
   localparam logic signed [MUL_W-1:0] CW_S = MUL_W'(CHUNK_WIDTH);
   localparam logic signed [MUL_W-1:0] CD_S = MUL_W'(CHUNK_DEPTH);
   localparam logic signed [MUL_W-1:0] SH_S = MUL_W'(SECTION_HEIGHT);
   localparam logic signed [MUL_W-1:0] CW_H = MUL_W'(CHUNK_WIDTH * 128);
   localparam logic signed [MUL_W-1:0] CD_H = MUL_W'(CHUNK_DEPTH * 128);
   localparam logic signed [MUL_W-1:0] SH_H = MUL_W'(SECTION_HEIGHT * 128);
   localparam logic [PIDX_W-1:0] LAST_PLANE = PIDX_W'(PLANE_COUNT - 1);
   localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_ACC  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [SY_W-1:0]         sy_ff, sy_in;
   logic [PIDX_W-1:0]       plane_ff, plane_in;
   logic [1:0]              axis_ff, axis_in;
   logic                    dist_ff, dist_in;
   logic [MASK_W-1:0]       mask_ff, mask_in;
   logic signed [CHK_W-1:0] cx_ff, cx_in, cz_ff, cz_in;
   res_type                 res_ff, res_in;

   logic signed [NRM_W-1:0] nrm_ff [PLANE_COUNT][AXES];
   logic signed [POS_W-1:0] ofs_ff [PLANE_COUNT];

   mac_ctl_type             mac_ctl;
   logic signed [MUL_W-1:0] op_a, op_b;
   logic signed [ACC_W-1:0] init_value, acc_sum;
   logic [PIDX_W-1:0]       ofs_idx;
   logic signed [NRM_W-1:0] nrm;
   logic signed [MUL_W-1:0] cx_ext, cz_ext, base_x, base_z, y_lo, lo, hi, corner;
   logic signed [MUL_W-1:0] dx, dy, dz, d;
   logic signed [MINSEC_W-1:0] min_sec, sy_s;
   logic                    below_hit, accept, last_sy;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign result       = res_ff;
   assign result_valid = (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (accept && req.operation == OP_LOAD && req.plane_index < PIDX_W'(PLANE_COUNT)) begin
         nrm_ff[req.plane_index][0] <= req.normal_x;
         nrm_ff[req.plane_index][1] <= req.normal_y;
         nrm_ff[req.plane_index][2] <= req.normal_z;
         ofs_ff[req.plane_index]    <= req.plane_offset;
      end
   end

   always_comb begin
      cx_ext = MUL_W'(cx_ff);
      cz_ext = MUL_W'(cz_ff);
      base_x = cx_ext * CW_S;
      base_z = cz_ext * CD_S;
      y_lo   = MUL_W'(sy_ff) * SH_S;
      nrm    = nrm_ff[plane_ff][axis_ff];
      unique case (axis_ff)
         2'd0: begin
            lo = base_x;
            hi = base_x + CW_S;
         end
         2'd1: begin
            lo = y_lo;
            hi = y_lo + SH_S;
         end
         default: begin
            lo = base_z;
            hi = base_z + CD_S;
         end
      endcase
      corner = (nrm >= 0) ? hi : lo;
      dx = (base_x <<< 8) + CW_H - MUL_W'(cam.x);
      dy = (y_lo <<< 8) + SH_H - MUL_W'(cam.y);
      dz = (base_z <<< 8) + CD_H - MUL_W'(cam.z);
      unique case (axis_ff)
         2'd0:    d = dx;
         2'd1:    d = dy;
         default: d = dz;
      endcase
      op_a = dist_ff ? d : MUL_W'(nrm);
      op_b = dist_ff ? d : (corner <<< 8);
      ofs_idx = (state_ff == S_SCAN) ? '0 : plane_ff + 1'b1;
      min_sec = MINSEC_W'(cam.section) - MINSEC_W'($signed({1'b0, cam.max_down}));
      sy_s    = $signed(MINSEC_W'(sy_ff));
      below_hit = (cam.max_down != '0) && (sy_s < min_sec);
      last_sy   = (sy_ff == LAST_SY);
   end

   always_comb begin
      state_in = state_ff;
      sy_in    = sy_ff;
      plane_in = plane_ff;
      axis_in  = axis_ff;
      dist_in  = dist_ff;
      mask_in  = mask_ff;
      cx_in    = cx_ff;
      cz_in    = cz_ff;
      res_in   = res_ff;
      mac_ctl  = '0;
      init_value = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req.operation == OP_QUERY) begin
               mask_in  = req.nonempty_mask;
               cx_in    = req.chunk_x;
               cz_in    = req.chunk_z;
               sy_in    = '0;
               res_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!mask_ff[sy_ff]) begin
               state_in = last_sy ? S_DONE : S_SCAN;
               sy_in    = sy_ff + 1'b1;
            end else begin
               res_in.tested_count = res_ff.tested_count + 1'b1;
               axis_in = '0;
               plane_in = '0;
               if (below_hit) begin
                  res_in.below_culled = res_ff.below_culled + 1'b1;
                  state_in = last_sy ? S_DONE : S_SCAN;
                  sy_in    = sy_ff + 1'b1;
               end else begin
                  dist_in      = !cam.frustum_en;
                  mac_ctl.init = 1'b1;
                  init_value   = cam.frustum_en ? (ACC_W'(ofs_ff[ofs_idx]) <<< 14) : '0;
                  state_in     = S_MUL;
               end
            end
         end
         S_MUL: begin
            mac_ctl.mul = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            if (axis_ff != LAST_AXIS) begin
               mac_ctl.acc = 1'b1;
               axis_in  = axis_ff + 1'b1;
               state_in = S_MUL;
            end else if (!dist_ff) begin
               axis_in = '0;
               if (acc_sum < 0) begin
                  res_in.frustum_culled = res_ff.frustum_culled + 1'b1;
                  state_in = last_sy ? S_DONE : S_SCAN;
                  sy_in    = sy_ff + 1'b1;
               end else if (plane_ff == LAST_PLANE) begin
                  dist_in      = 1'b1;
                  mac_ctl.init = 1'b1;
                  state_in     = S_MUL;
               end else begin
                  plane_in     = plane_ff + 1'b1;
                  mac_ctl.init = 1'b1;
                  init_value   = ACC_W'(ofs_ff[ofs_idx]) <<< 14;
                  state_in     = S_MUL;
               end
            end else begin
               if (acc_sum > DIST_LIMIT) begin
                  res_in.distance_culled = res_ff.distance_culled + 1'b1;
               end else begin
                  res_in.visible_mask[sy_ff] = 1'b1;
               end
               state_in = last_sy ? S_DONE : S_SCAN;
               sy_in    = sy_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (result_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sy_ff    <= sy_in;
      plane_ff <= plane_in;
      axis_ff  <= axis_in;
      dist_ff  <= dist_in;
      mask_ff  <= mask_in;
      cx_ff    <= cx_in;
      cz_ff    <= cz_in;
      res_ff   <= res_in;
   end

   svm_mac u_mac (
      .clock      (clock),
      .ctl        (mac_ctl),
      .a          (op_a),
      .b          (op_b),
      .init_value (init_value),
      .acc_sum    (acc_sum)
   );
endmodule

// ===== src/section_visibility_mask_unit.sv =====
`timescale 1ns / 1ps
// Top level: control registers, response register, sequencer instance.
// Depends on svm_pkg, svm_req_if, svm_rsp_if, svm_seq.
//
// Usage:
//   req_port carries plane loads (operation 0) and chunk queries (operation 1).
//   A load gives no response and is taken only while idle; a load with plane index
//   above 5 is dropped. A query gives one transfer on rsp_port with the
//   visible mask and the cull counts.
//   csr_* writes the camera registers; write only while no query is in flight.
//   A query walks the sections in order. An empty or below-limit section is
//   passed over; a tested section sums the plane terms for 6 planes by 3
//   axes and is dropped at the first plane with a negative sum, and a section
//   that passes all planes then sums 3 squared distance terms; a query with
//   frustum test off goes straight to the distance terms. The result passes
//   through the response register, and the unit returns to idle before the
//   next request transfer. All products come from the single multiplier.
//   req_port.ready stays low while a query runs and while its result waits
//   for the response register; the register holds it while rsp_port stalls.
//   Reset clears the camera registers (frustum test enabled), the sequencer
//   state and the response valid; the plane store holds nothing until loaded.
module section_visibility_mask_unit #(
   parameter int SECTIONS       = svm_pkg::SECTIONS_DEF,
   parameter int CHUNK_WIDTH    = svm_pkg::CHUNK_WIDTH_DEF,
   parameter int CHUNK_DEPTH    = svm_pkg::CHUNK_DEPTH_DEF,
   parameter int SECTION_HEIGHT = svm_pkg::SECTION_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   svm_req_if.sink                           req_port,
   svm_rsp_if.source                         rsp_port,
   input  logic                              csr_write_enable,
   input  logic [svm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [svm_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import svm_pkg::*;

   localparam int NSEC = (SECTIONS < MASK_W) ? SECTIONS : MASK_W;

   cam_type cam_ff, cam_in;
   res_type rsp_ff, rsp_in, result;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    result_valid, result_take;

   always_comb begin
      cam_in = cam_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_CAMERA_X:   cam_in.x          = csr_write_data;
            REG_CAMERA_Y:   cam_in.y          = csr_write_data;
            REG_CAMERA_Z:   cam_in.z          = csr_write_data;
            REG_CAMERA_SEC: cam_in.section    = csr_write_data[CSEC_W-1:0];
            REG_MAX_DOWN:   cam_in.max_down   = csr_write_data[DOWN_W-1:0];
            REG_FRUSTUM_EN: cam_in.frustum_en = csr_write_data[0];
            default:        cam_in = cam_ff;
         endcase
      end
   end

   assign result_take  = result_valid && (!rsp_valid_ff || rsp_port.ready);
   assign rsp_valid_in = result_take || (rsp_valid_ff && !rsp_port.ready);
   assign rsp_in       = result_take ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff       <= '{x: '0, y: '0, z: '0, section: '0, max_down: '0, frustum_en: 1'b1};
         rsp_valid_ff <= 1'b0;
      end else begin
         cam_ff       <= cam_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.visible_mask    = rsp_ff.visible_mask;
   assign rsp_port.tested_count    = rsp_ff.tested_count;
   assign rsp_port.below_culled    = rsp_ff.below_culled;
   assign rsp_port.frustum_culled  = rsp_ff.frustum_culled;
   assign rsp_port.distance_culled = rsp_ff.distance_culled;

   svm_seq #(
      .SECTIONS       (SECTIONS),
      .CHUNK_WIDTH    (CHUNK_WIDTH),
      .CHUNK_DEPTH    (CHUNK_DEPTH),
      .SECTION_HEIGHT (SECTION_HEIGHT)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req          (req_port),
      .cam          (cam_ff),
      .result       (result),
      .result_valid (result_valid),
      .result_take  (result_take)
   );

   a_counts_add_up: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (32'(rsp_port.tested_count) == 32'(rsp_port.below_culled)
         + 32'(rsp_port.frustum_culled) + 32'(rsp_port.distance_culled)
         + 32'($countones(rsp_port.visible_mask))))
      else $error("cull counts do not sum to tested count");

   a_tested_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (32'(rsp_port.tested_count) <= NSEC))
      else $error("tested count exceeds section count");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> !req_port.ready)
      else $error("request accepted while a result is pending");
endmodule
